FILE: src/spq_pkg.sv
// Package: shared types, codes and defaults for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int DEPTH_DEF    = 16;
  localparam int TAG_BITS_DEF = 16;

  localparam logic [3:0] PRIO_MIN = 4'd1;
  localparam logic [3:0] PRIO_MAX = 4'd10;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_REMOVE = 1'b1;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_EMPTY   = 2'd1;
  localparam logic [1:0] ST_FULL    = 2'd2;
  localparam logic [1:0] ST_BADPRIO = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [3:0]  priority_req;
    logic [15:0] tag;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        popped_valid;
    logic [3:0]  popped_priority;
    logic [15:0] popped_tag;
    logic [4:0]  occupancy;
  } out_t;

  // Broadcast to every cell in the cycle an item is applied.
  typedef struct packed {
    logic       do_insert;
    logic       do_remove;
    logic [3:0] new_prio;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: src/spq_cell.sv
// One storage cell of the sorted chain: holds an entry, shifts left or right, or takes the new one.
`default_nettype none
module spq_cell import spq_pkg::*; #(
  parameter int TW  = 16,
  parameter int CW  = 5,
  parameter int IDX = 0
) (
  input  wire logic          clk,
  input  wire cell_ctl_t     ctl,
  input  wire logic [TW-1:0] new_tag,
  input  wire logic [CW-1:0] count,
  input  wire logic          left_ge,
  input  wire logic [3:0]    left_prio,
  input  wire logic [TW-1:0] left_tag,
  input  wire logic [3:0]    right_prio,
  input  wire logic [TW-1:0] right_tag,
  output logic               ge,
  output logic [3:0]         prio,
  output logic [TW-1:0]      tag
);

  logic [3:0]    prio_r, prio_nxt;
  logic [TW-1:0] tag_r, tag_nxt;
  logic          occupied;

  // Cells below the fill count hold entries; the rest are don't-care.
  assign occupied = count > CW'(IDX);
  assign ge       = occupied && (prio_r >= ctl.new_prio);

  always_comb begin
    prio_nxt = prio_r;
    tag_nxt  = tag_r;
    if (ctl.do_remove) begin
      prio_nxt = right_prio;
      tag_nxt  = right_tag;
    end else if (ctl.do_insert && !ge) begin
      // The new entry lands behind the last entry of equal or higher priority.
      if (left_ge) begin
        prio_nxt = ctl.new_prio;
        tag_nxt  = new_tag;
      end else begin
        prio_nxt = left_prio;
        tag_nxt  = left_tag;
      end
    end
  end

  always_ff @(posedge clk) begin
    prio_r <= prio_nxt;
    tag_r  <= tag_nxt;
  end

  assign prio = prio_r;
  assign tag  = tag_r;

endmodule
`default_nettype wire

FILE: src/sorted_priority_queue_unit.sv
// Top level: sorted priority queue built as a chain of entry cells with a registered result.
`default_nettype none
// A bounded priority queue held as a row of DEPTH cells, highest priority at
// cell 0 and equal priorities in arrival order. Every cell compares its entry
// with the incoming priority at once, so an insert or a remove completes in
// one row update: one item is accepted per cycle while in_ready is high, and
// its result is in the result register in the next cycle. in_ready is high whenever
// that register is empty or is being taken in the same cycle, so items stream back
// to back while the result side keeps up. Tags keep their low TAG_BITS bits, up to 16.
module sorted_priority_queue_unit import spq_pkg::*; #(
  parameter int DEPTH    = DEPTH_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_valid,
  output logic      in_ready,
  input  wire in_t  in_data,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_t      out_data
);

  localparam int TW = (TAG_BITS < 16) ? TAG_BITS : 16;
  localparam int CW = $clog2(DEPTH + 1);

  logic [CW-1:0] count_r, count_nxt;
  logic          out_valid_r, out_valid_nxt;
  out_t          out_r, out_nxt;

  logic          accept;
  logic          is_insert;
  logic          bad_prio;
  logic          full;
  logic          empty;
  cell_ctl_t     ctl;
  logic [TW-1:0] new_tag;

  logic [3:0]    prio_w [DEPTH+1];
  logic [TW-1:0] tag_w  [DEPTH+1];
  logic          ge_w   [DEPTH+1];

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign is_insert = in_data.opcode == OP_INSERT;
  assign bad_prio  = (in_data.priority_req < PRIO_MIN) || (in_data.priority_req > PRIO_MAX);
  assign full      = count_r == CW'(DEPTH);
  assign empty     = count_r == '0;
  assign new_tag   = TW'(in_data.tag);

  assign ctl.do_insert = accept && is_insert && !bad_prio && !full;
  assign ctl.do_remove = accept && !is_insert && !empty;
  assign ctl.new_prio  = in_data.priority_req;

  // Cell 0 sees an always-winning left neighbour; the last cell shifts in a blank.
  assign ge_w[0]       = 1'b1;
  assign prio_w[DEPTH] = '0;
  assign tag_w[DEPTH]  = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [3:0]    lp;
    logic [TW-1:0] lt;
    if (i == 0) begin : g_head
      assign lp = '0;
      assign lt = '0;
    end else begin : g_body
      assign lp = prio_w[i-1];
      assign lt = tag_w[i-1];
    end
    spq_cell #(
      .TW  (TW),
      .CW  (CW),
      .IDX (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .new_tag    (new_tag),
      .count      (count_r),
      .left_ge    (ge_w[i]),
      .left_prio  (lp),
      .left_tag   (lt),
      .right_prio (prio_w[i+1]),
      .right_tag  (tag_w[i+1]),
      .ge         (ge_w[i+1]),
      .prio       (prio_w[i]),
      .tag        (tag_w[i])
    );
  end

  always_comb begin
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (ctl.do_insert) begin
      count_nxt = count_r + CW'(1);
    end else if (ctl.do_remove) begin
      count_nxt = count_r - CW'(1);
    end
    if (accept) begin
      out_valid_nxt           = 1'b1;
      out_nxt.popped_valid    = 1'b0;
      out_nxt.popped_priority = '0;
      out_nxt.popped_tag      = '0;
      if (is_insert) begin
        if (bad_prio) begin
          out_nxt.status = ST_BADPRIO;
        end else if (full) begin
          out_nxt.status = ST_FULL;
        end else begin
          out_nxt.status = ST_OK;
        end
      end else if (empty) begin
        out_nxt.status = ST_EMPTY;
      end else begin
        out_nxt.status          = ST_OK;
        out_nxt.popped_valid    = 1'b1;
        out_nxt.popped_priority = prio_w[0];
        out_nxt.popped_tag      = 16'(tag_w[0]);
      end
      out_nxt.occupancy = 5'(count_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire
